// ===== rtl/cc_pkg.sv =====
// shared constants, types and the gcd helper function of the calendar clock
package cc_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DAY_MINUTES   = 1440;
  localparam int DAY_FIXED     = DAY_MINUTES << FRACTION_BITS;
  localparam int IN_W          = 19;
  localparam int TIME_W        = $clog2(DAY_FIXED);
  localparam int WHOLE_W       = TIME_W - FRACTION_BITS;

  localparam int SUN_FULL      = 360 * 256;
  localparam int SUN_OFFSET    = 90 * 256;
  localparam int SUN_W         = 17;

  localparam int QUEUE_DEPTH   = 2;

  function automatic int gcd(input int a, input int b);
    int x;
    int y;
    x = a;
    y = b;
    while (x != y) begin
      if (x > y) begin
        x = x - y;
      end else begin
        y = y - x;
      end
    end
    return x;
  endfunction

  // sun angle scale reduced to a multiply and a shift
  localparam int SUN_G     = gcd(SUN_FULL, DAY_FIXED);
  localparam int SUN_NUM   = SUN_FULL / SUN_G;
  localparam int SUN_SHIFT = $clog2(DAY_FIXED / SUN_G);
  localparam int SUN_NUM_W = $clog2(SUN_NUM + 1);

  // reciprocal of 60 for whole minutes below one day
  localparam int MIN_SHIFT = 16;
  localparam int MIN_MUL   = ((1 << MIN_SHIFT) + 59) / 60;
  localparam int MIN_MUL_W = $clog2(MIN_MUL + 1);

  localparam logic [15:0] YEAR_MAX_BCD = 16'h9999;

  typedef struct packed {
    logic [TIME_W-1:0] time_of_day;
    logic [15:0]       year_bcd;
    logic [4:0]        month_bcd;
    logic [5:0]        day_bcd;
  } cc_entry_t;

  typedef struct packed {
    logic [SUN_W-1:0] sun_angle;
    logic             pm_flag;
    logic [6:0]       minute_bcd;
    logic [4:0]       hour_bcd;
    logic [5:0]       day_bcd;
    logic [4:0]       month_bcd;
    logic [15:0]      year_bcd;
  } cc_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cc_queue_status_t;

endpackage

// ===== rtl/cc_front.sv =====
// front part: accepts elapsed time, keeps time of day and the bcd calendar
module cc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [cc_pkg::IN_W-1:0]  elapsed_i,
  input  cc_pkg::cc_queue_status_t status_i,
  output logic                     push_o,
  output cc_pkg::cc_entry_t        entry_o
);
  import cc_pkg::*;

  logic [TIME_W-1:0] time_q, time_d;
  logic [15:0]       year_q, year_d;
  logic [4:0]        month_q, month_d;
  logic [5:0]        day_q, day_d;

  logic [IN_W-1:0]   dt;
  logic [TIME_W:0]   sum;
  logic              wrap;
  logic [5:0]        last_day;
  logic              leap;
  logic [1:0]        low_mod4;
  logic [1:0]        cent_mod4;
  logic [15:0]       year_inc;
  logic [5:0]        day_inc;
  logic [4:0]        month_inc;
  logic              accept;

  assign ready_o = !status_i.full;
  assign accept  = valid_i && !status_i.full;
  assign push_o  = accept;

  always_comb begin
    if (elapsed_i >= IN_W'(DAY_FIXED)) begin
      dt = IN_W'(DAY_FIXED - 1);
    end else begin
      dt = elapsed_i;
    end
  end

  assign sum  = {1'b0, time_q} + (TIME_W + 1)'(dt);
  assign wrap = sum >= (TIME_W + 1)'(DAY_FIXED);

  // leap rule on bcd digits
  assign low_mod4  = {year_q[4], 1'b0} + year_q[1:0];
  assign cent_mod4 = {year_q[12], 1'b0} + year_q[9:8];
  assign leap      = (year_q[7:0] == 8'h00) ? (cent_mod4 == 2'd0) : (low_mod4 == 2'd0);

  always_comb begin
    unique case (month_q) inside
      5'h02:                      last_day = leap ? 6'h29 : 6'h28;
      5'h04, 5'h06, 5'h09, 5'h11: last_day = 6'h30;
      default:                    last_day = 6'h31;
    endcase
  end

  always_comb begin
    if (day_q[3:0] == 4'd9) begin
      day_inc = {day_q[5:4] + 2'd1, 4'd0};
    end else begin
      day_inc = {day_q[5:4], day_q[3:0] + 4'd1};
    end
    if (month_q[3:0] == 4'd9) begin
      month_inc = {1'b1, 4'd0};
    end else begin
      month_inc = {month_q[4], month_q[3:0] + 4'd1};
    end
    year_inc = year_q;
    if (year_q[3:0] != 4'd9) begin
      year_inc[3:0] = year_q[3:0] + 4'd1;
    end else begin
      year_inc[3:0] = 4'd0;
      if (year_q[7:4] != 4'd9) begin
        year_inc[7:4] = year_q[7:4] + 4'd1;
      end else begin
        year_inc[7:4] = 4'd0;
        if (year_q[11:8] != 4'd9) begin
          year_inc[11:8] = year_q[11:8] + 4'd1;
        end else begin
          year_inc[11:8]  = 4'd0;
          year_inc[15:12] = year_q[15:12] + 4'd1;
        end
      end
    end
  end

  always_comb begin
    time_d  = time_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    if (accept) begin
      if (wrap) begin
        time_d = TIME_W'(sum - (TIME_W + 1)'(DAY_FIXED));
        if (day_q == last_day) begin
          day_d = 6'h01;
          if (month_q == 5'h12) begin
            month_d = 5'h01;
            if (year_q != YEAR_MAX_BCD) begin
              year_d = year_inc;
            end
          end else begin
            month_d = month_inc;
          end
        end else begin
          day_d = day_inc;
        end
      end else begin
        time_d = sum[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      day_q   <= 6'h01;
      month_q <= 5'h01;
      year_q  <= 16'h0001;
    end else begin
      time_q  <= time_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
    end
  end

  assign entry_o.time_of_day = time_d;
  assign entry_o.year_bcd    = year_d;
  assign entry_o.month_bcd   = month_d;
  assign entry_o.day_bcd     = day_d;

endmodule

// ===== rtl/cc_fifo.sv =====
// short queue of updated calendar entries between front and back
module cc_fifo #(
  parameter int DEPTH = cc_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cc_pkg::cc_entry_t        entry_i,
  input  logic                     pop_i,
  output cc_pkg::cc_entry_t        entry_o,
  output cc_pkg::cc_queue_status_t status_o
);
  import cc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cc_entry_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = count_q == CNT_W'(DEPTH);
  assign status_o.empty = count_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/cc_back.sv =====
// back part: 12-hour time, bcd minute and sun angle into the output register
module cc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cc_pkg::cc_entry_t        entry_i,
  input  cc_pkg::cc_queue_status_t status_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cc_pkg::cc_result_t       result_o
);
  import cc_pkg::*;

  localparam int PROD60_W = WHOLE_W + MIN_MUL_W;
  localparam int SUNP_W   = TIME_W + SUN_NUM_W;

  logic                valid_q, valid_d;
  cc_result_t          result_q;
  cc_result_t          result_d;

  logic [WHOLE_W-1:0]  whole;
  logic [PROD60_W-1:0] prod60;
  logic [4:0]          hod;
  logic [WHOLE_W-1:0]  minute_w;
  logic [5:0]          minute;
  logic [3:0]          h12;
  logic [13:0]         prod10;
  logic [2:0]          min_tens;
  logic [3:0]          min_units;
  logic [SUNP_W-1:0]   sun_prod;
  logic [SUN_W-1:0]    sun_raw;

  assign pop_o = !status_i.empty && (!valid_q || ready_i);

  assign whole    = entry_i.time_of_day[TIME_W-1:FRACTION_BITS];
  assign prod60   = PROD60_W'(whole) * PROD60_W'(MIN_MUL);
  assign hod      = 5'(prod60 >> MIN_SHIFT);
  assign minute_w = whole - WHOLE_W'(hod) * WHOLE_W'(60);
  assign minute   = minute_w[5:0];

  assign prod10    = 14'(minute) * 14'd205;
  assign min_tens  = prod10[13:11];
  assign min_units = 4'(minute - 6'(min_tens) * 6'd10);

  assign sun_prod = SUNP_W'(entry_i.time_of_day) * SUNP_W'(SUN_NUM);
  assign sun_raw  = SUN_W'(sun_prod >> SUN_SHIFT);

  always_comb begin
    result_d.year_bcd   = entry_i.year_bcd;
    result_d.month_bcd  = entry_i.month_bcd;
    result_d.day_bcd    = entry_i.day_bcd;
    result_d.pm_flag    = hod >= 5'd12;
    h12 = result_d.pm_flag ? 4'(hod - 5'd12) : hod[3:0];
    if (h12 == 4'd0) begin
      result_d.hour_bcd = 5'h12;
    end else if (h12 >= 4'd10) begin
      result_d.hour_bcd = {1'b1, h12 - 4'd10};
    end else begin
      result_d.hour_bcd = {1'b0, h12};
    end
    result_d.minute_bcd = {min_tens, min_units};
    if (sun_raw >= SUN_W'(SUN_OFFSET)) begin
      result_d.sun_angle = sun_raw - SUN_W'(SUN_OFFSET);
    end else begin
      result_d.sun_angle = sun_raw + SUN_W'(SUN_FULL - SUN_OFFSET);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/calendar_clock.sv =====
// top level of the calendar clock: front, queue and back
// Each input transfer adds an elapsed time, in minutes with 8 fraction bits, to the time of
// day; a full day advances the Gregorian date (year held at 9999) and one result transfer
// reports the bcd date, the 12-hour bcd time, the pm flag and the sun angle. The block
// takes one transfer per cycle while the queue is not full; the front part updates the time
// and date combinationally, the queue holds the update and the back part loads its result
// into the output register when it pops it. While the output is stalled the two-entry
// queue between front and back takes two more input transfers before the input stalls.
module calendar_clock #(
  parameter int QUEUE_DEPTH = cc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // elapsed_minutes[18:0]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // year_bcd[15:0], month_bcd[20:16], day_bcd[26:21], hour_bcd[31:27],
  // minute_bcd[38:32], pm_flag[39], sun_angle[56:40]
  output logic [63:0] m_axis_tdata
);
  import cc_pkg::*;

  cc_queue_status_t status;
  cc_entry_t        push_entry;
  cc_entry_t        pop_entry;
  cc_result_t       result;
  logic             push;
  logic             pop;

  cc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .elapsed_i (s_axis_tdata[IN_W-1:0]),
    .status_i  (status),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  cc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (status)
  );

  cc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (pop_entry),
    .status_i (status),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {7'd0, result};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench of the calendar clock: random and directed time steps checked against a predictor
module testbench;
  import cc_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_STEPS  = 1084;
  localparam int PHASE_LENGTH  = 150;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int YEAR_LIMIT    = 9999;
  localparam int ELAPSED_MAX   = (1 << IN_W) - 1;

  typedef enum int unsigned {
    PHASE_STREAM,
    PHASE_SENDER_IDLE,
    PHASE_RECEIVER_STALL,
    PHASE_BOTH
  } idle_phase_e;

  typedef struct {
    logic [IN_W-1:0] elapsed;
    idle_phase_e     phase;
  } time_step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  time_step_t  pending_steps[$];
  cc_result_t  expected_readings[$];
  int          error_count;
  int          readings_seen;
  int          cycle_count;

  // predictor state
  longint      clock_fixed;
  int          cal_day;
  int          cal_month;
  int          cal_year;

  calendar_clock DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] bcd_digits(input int value);
    logic [15:0] digits;
    int          rest;
    digits = '0;
    rest   = value;
    for (int i = 0; i < 4; i++) begin
      digits[i*4 +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
    return digits;
  endfunction

  function automatic int days_in_month(input int month, input int year);
    if (month == 2) begin
      if ((year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0))) begin
        return 29;
      end
      return 28;
    end
    if (month == 4 || month == 6 || month == 9 || month == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic int sender_idle_pct(input idle_phase_e phase);
    case (phase)
      PHASE_SENDER_IDLE: return 72;
      PHASE_BOTH:        return 13;
      default:           return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input idle_phase_e phase);
    case (phase)
      PHASE_RECEIVER_STALL: return 72;
      PHASE_BOTH:           return 13;
      default:              return 0;
    endcase
  endfunction

  task automatic advance_calendar(input logic [IN_W-1:0] elapsed);
    longint     step;
    longint     whole;
    longint     hour_of_day;
    longint     angle;
    int         hour12;
    cc_result_t reading;
    step = longint'(elapsed);
    if (step >= DAY_FIXED) begin
      step = DAY_FIXED - 1;
    end
    clock_fixed += step;
    if (clock_fixed >= DAY_FIXED) begin
      clock_fixed -= DAY_FIXED;
      cal_day++;
      if (cal_day > days_in_month(cal_month, cal_year)) begin
        cal_day = 1;
        cal_month++;
      end
      if (cal_month > 12) begin
        cal_month = 1;
        if (cal_year < YEAR_LIMIT) begin
          cal_year++;
        end
      end
    end
    whole       = clock_fixed >> FRACTION_BITS;
    hour_of_day = (whole / 60) % 24;
    hour12      = int'(hour_of_day % 12);
    if (hour12 == 0) begin
      hour12 = 12;
    end
    angle = (clock_fixed * SUN_FULL) / DAY_FIXED;
    angle = angle % SUN_FULL;
    angle = (angle >= SUN_OFFSET) ? angle - SUN_OFFSET : angle + SUN_FULL - SUN_OFFSET;

    reading.year_bcd   = bcd_digits(cal_year);
    reading.month_bcd  = 5'(bcd_digits(cal_month));
    reading.day_bcd    = 6'(bcd_digits(cal_day));
    reading.hour_bcd   = 5'(bcd_digits(hour12));
    reading.minute_bcd = 7'(bcd_digits(int'(whole % 60)));
    reading.pm_flag    = (hour_of_day >= 12);
    reading.sun_angle  = SUN_W'(angle);
    expected_readings.push_back(reading);
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        advance_calendar(s_axis_tdata[IN_W-1:0]);
      end
      if (pending_steps.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct(pending_steps[0].phase)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 24'(pending_steps[0].elapsed);
        void'(pending_steps.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cc_result_t actual;
    cc_result_t expected;
    idle_phase_e phase;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        actual = cc_result_t'(m_axis_tdata[$bits(cc_result_t)-1:0]);
        if (expected_readings.size() == 0) begin
          $error("result transfer with no expected result: %h", m_axis_tdata);
          error_count++;
        end else begin
          expected = expected_readings.pop_front();
          check_field("year_bcd", expected.year_bcd, actual.year_bcd);
          check_field("month_bcd", expected.month_bcd, actual.month_bcd);
          check_field("day_bcd", expected.day_bcd, actual.day_bcd);
          check_field("hour_bcd", expected.hour_bcd, actual.hour_bcd);
          check_field("minute_bcd", expected.minute_bcd, actual.minute_bcd);
          check_field("pm_flag", expected.pm_flag, actual.pm_flag);
          check_field("sun_angle", expected.sun_angle, actual.sun_angle);
        end
        readings_seen++;
      end
      phase = idle_phase_e'((readings_seen / PHASE_LENGTH) % 4);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct(phase));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("calendar_clock: mismatch");
      $finish;
    end
  end

  task automatic queue_step(input int elapsed, input idle_phase_e phase);
    time_step_t step;
    step.elapsed = IN_W'(elapsed);
    step.phase   = phase;
    pending_steps.push_back(step);
  endtask

  initial begin
    int elapsed;
    error_count   = 0;
    readings_seen = 0;
    cycle_count   = 0;
    clock_fixed   = 0;
    cal_day       = 1;
    cal_month     = 1;
    cal_year      = 1;
    rst_ni        = 1'b0;

    // zero step, smallest step, then a step landing exactly on a full day
    queue_step(0, PHASE_STREAM);
    queue_step(1, PHASE_STREAM);
    queue_step(DAY_FIXED - 1, PHASE_STREAM);
    // one full day and the widest value both saturate
    queue_step(DAY_FIXED, PHASE_STREAM);
    queue_step(1, PHASE_STREAM);
    queue_step(ELAPSED_MAX, PHASE_STREAM);
    queue_step(DAY_FIXED + 1, PHASE_STREAM);
    // hour and noon boundaries
    queue_step(59 * 256 + 255, PHASE_STREAM);
    queue_step(1, PHASE_STREAM);
    queue_step(660 * 256, PHASE_STREAM);
    queue_step(59 * 256, PHASE_STREAM);
    queue_step(1 * 256, PHASE_STREAM);
    queue_step(360 * 256, PHASE_STREAM);
    queue_step(359 * 256 + 255, PHASE_STREAM);
    queue_step(32'h2AAAA, PHASE_STREAM);
    queue_step(32'h55555, PHASE_STREAM);

    // mostly near-day steps so the date runs across year ends
    for (int i = 0; i < RANDOM_STEPS; i++) begin
      if ($urandom_range(99) < 95) begin
        elapsed = $urandom_range(ELAPSED_MAX, DAY_FIXED - 1);
      end else begin
        elapsed = $urandom_range(ELAPSED_MAX, 0);
      end
      queue_step(elapsed, idle_phase_e'((i / PHASE_LENGTH) % 4));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_steps.size() > 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    while (expected_readings.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("calendar_clock: match");
    end else begin
      $display("calendar_clock: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cc_pkg.sv
rtl/cc_front.sv
rtl/cc_fifo.sv
rtl/cc_back.sv
rtl/calendar_clock.sv
tb/sv/testbench.sv
